[rtl/kvdt_pkg.sv]
// Shared types, codes and constants of the key/value table.
package kvdt_pkg;

    // Default table depth
    localparam int unsigned ENTRIES_DEF = 16;

    // Field widths
    localparam int unsigned OP_W  = 2;
    localparam int unsigned KEY_W = 32;
    localparam int unsigned VAL_W = 32;
    localparam int unsigned ST_W  = 3;

    // Stream payload widths
    localparam int unsigned IN_DATA_W  = KEY_W + VAL_W;
    localparam int unsigned IN_USER_W  = OP_W;
    localparam int unsigned OUT_DATA_W = VAL_W;
    localparam int unsigned OUT_USER_W = 1 + ST_W;

    // Operation codes; the unused code behaves as a search
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_SEARCH = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Result status codes
    localparam logic [ST_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [ST_W-1:0] STAT_FOUND     = 3'd2;
    localparam logic [ST_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [ST_W-1:0] STAT_DELETED   = 3'd4;
    localparam logic [ST_W-1:0] STAT_EMPTY     = 3'd5;
    localparam logic [ST_W-1:0] STAT_FULL      = 3'd6;

    // One table slot as held in memory
    typedef struct packed {
        logic             vld;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } t_slot;

    // Controller states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_wr;    // write an empty slot at the sweep address
        logic load_req;  // capture a request beat and restart the scan
        logic scan_rd;   // read the slot at the sweep address
        logic commit;    // update the table and load the result register
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic addr_last; // sweep address is at the last slot
        logic out_free;  // result register can take a new result
    } t_dp_sts;

endpackage

[rtl/kvdt_ctrl.sv]
// Controller state machine of the key/value table.
module kvdt_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  kvdt_pkg::t_dp_sts i_sts,
    output kvdt_pkg::t_dp_cmd o_cmd
);
    import kvdt_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register; reset starts the clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.addr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_in_valid) n_state = S_SCAN;
            end
            S_SCAN: begin
                if (i_sts.addr_last) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_COMMIT;
            end
            S_COMMIT: begin
                if (i_sts.out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Outputs
    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        o_cmd.clr_wr   = (r_state == S_CLEAR);
        o_cmd.load_req = (r_state == S_IDLE) && i_in_valid;
        o_cmd.scan_rd  = (r_state == S_SCAN);
        o_cmd.commit   = (r_state == S_COMMIT) && i_sts.out_free;
    end

endmodule

[rtl/kvdt_datapath.sv]
// Datapath of the key/value table: slot memory, scan, match tracking, result register.
module kvdt_datapath #(
    parameter int unsigned ENTRIES = kvdt_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  kvdt_pkg::t_dp_cmd          i_cmd,
    output kvdt_pkg::t_dp_sts          o_sts,
    input  logic [kvdt_pkg::OP_W-1:0]  i_op,
    input  logic [kvdt_pkg::KEY_W-1:0] i_key,
    input  logic [kvdt_pkg::VAL_W-1:0] i_value,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_found,
    output logic [kvdt_pkg::VAL_W-1:0] o_read_value,
    output logic [kvdt_pkg::ST_W-1:0]  o_status
);
    import kvdt_pkg::*;

    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned CW = $clog2(ENTRIES + 1);
    localparam logic [AW-1:0] LAST_ADDR = AW'(ENTRIES - 1);

    // Slot memory
    t_slot r_mem [ENTRIES];
    t_slot r_rdata;

    // Request registers
    logic [OP_W-1:0]  r_op;
    logic [KEY_W-1:0] r_key;
    logic [VAL_W-1:0] r_value;

    // Sweep address and compare tag
    logic [AW-1:0] r_addr;
    logic [AW-1:0] r_cmp_idx;
    logic          r_cmp_vld;

    // Scan results
    logic             r_hit;
    logic [AW-1:0]    r_hit_idx;
    logic [VAL_W-1:0] r_hit_val;
    logic             r_free_ok;
    logic [AW-1:0]    r_free_idx;

    // Number of valid slots
    logic [CW-1:0] r_count;

    // Result register
    logic             r_out_valid;
    logic             r_out_found;
    logic [VAL_W-1:0] r_out_rd;
    logic [ST_W-1:0]  r_out_status;

    // Commit decision
    logic          c_wr;
    logic [AW-1:0] c_wr_addr;
    t_slot         c_wr_slot;
    logic          c_inc;
    logic          c_dec;
    logic [ST_W-1:0] c_status;

    assign o_sts.addr_last = (r_addr == LAST_ADDR);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    // Capture the request beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_op    <= i_op;
            r_key   <= i_key;
            r_value <= i_value;
        end
    end

    // Advance the sweep address during clearing and scanning
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else if (i_cmd.load_req) begin
            r_addr <= '0;
        end else if (i_cmd.clr_wr || i_cmd.scan_rd) begin
            if (r_addr == LAST_ADDR) begin
                r_addr <= '0;
            end else begin
                r_addr <= r_addr + AW'(1);
            end
        end
    end

    // Read one slot per cycle and tag it
    always_ff @(posedge i_clk) begin
        r_rdata   <= r_mem[r_addr];
        r_cmp_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld <= 1'b0;
        end else begin
            r_cmp_vld <= i_cmd.scan_rd;
        end
    end

    // Track the matching slot and the lowest free slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (i_cmd.load_req) begin
            r_hit     <= 1'b0;
            r_free_ok <= 1'b0;
        end else if (r_cmp_vld) begin
            if (r_rdata.vld && (r_rdata.key == r_key) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_cmp_idx;
                r_hit_val <= r_rdata.val;
            end
            if (!r_rdata.vld && !r_free_ok) begin
                r_free_ok  <= 1'b1;
                r_free_idx <= r_cmp_idx;
            end
        end
    end

    // Decide the table update and the status
    always_comb begin
        c_wr      = 1'b0;
        c_wr_addr = r_hit_idx;
        c_wr_slot = '{vld: 1'b1, key: r_key, val: r_value};
        c_inc     = 1'b0;
        c_dec     = 1'b0;
        c_status  = r_hit ? STAT_FOUND : STAT_NOT_FOUND;
        unique case (r_op)
            OP_INSERT: begin
                if (r_hit) begin
                    c_wr     = 1'b1;
                    c_status = STAT_UPDATED;
                end else if (r_free_ok) begin
                    c_wr      = 1'b1;
                    c_wr_addr = r_free_idx;
                    c_inc     = 1'b1;
                    c_status  = STAT_INSERTED;
                end else begin
                    c_status = STAT_FULL;
                end
            end
            OP_DELETE: begin
                if (r_count == '0) begin
                    c_status = STAT_EMPTY;
                end else if (r_hit) begin
                    c_wr      = 1'b1;
                    c_wr_slot = '{vld: 1'b0, key: r_key, val: r_hit_val};
                    c_dec     = 1'b1;
                    c_status  = STAT_DELETED;
                end else begin
                    c_status = STAT_NOT_FOUND;
                end
            end
            default: begin
                c_status = r_hit ? STAT_FOUND : STAT_NOT_FOUND;
            end
        endcase
    end

    // Write the slot memory: empty slots while clearing, else the commit
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_wr) begin
            r_mem[r_addr] <= '0;
        end else if (i_cmd.commit && c_wr) begin
            r_mem[c_wr_addr] <= c_wr_slot;
        end
    end

    // Keep the number of valid slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.commit) begin
            if (c_inc) begin
                r_count <= r_count + CW'(1);
            end else if (c_dec) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Hold the result until the receiver takes the beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_found  <= r_hit;
            r_out_rd     <= r_hit ? r_hit_val : '1;
            r_out_status <= c_status;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_found      = r_out_found;
    assign o_read_value = r_out_rd;
    assign o_status     = r_out_status;

endmodule

[rtl/key_value_dictionary_table.sv]
// Top level of the key/value table: stream ports, controller and datapath.
//
// Request channel (s_axis): tuser carries the operation (insert/update,
// search, delete), tdata the key and the value. Result channel (m_axis):
// one beat per request with the found flag, the status code and the value
// held for the key before the request (all ones when the key was absent).
//
// Each request scans every slot of the table through one memory read port,
// one slot per cycle, then decides and writes the update back when the
// result register is free. A request passes the scan, drain and commit
// states before the controller is idle again; the result is registered
// at the commit. Only one request is in flight at a time; a new request
// is accepted while the previous result still waits in the output register.
//
// After reset the table is cleared by a sweep that writes one empty slot
// per cycle over every slot, with the request channel not ready.
// When the receiver stalls, the result is held; a following request is
// scanned but its result waits until the output register is free.
module key_value_dictionary_table #(
    parameter int unsigned ENTRIES = kvdt_pkg::ENTRIES_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [kvdt_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,  // key, value
    input  logic [kvdt_pkg::IN_USER_W-1:0]  i_s_axis_tuser,  // op
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [kvdt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,  // read_value
    output logic [kvdt_pkg::OUT_USER_W-1:0] o_m_axis_tuser   // found, status
);
    import kvdt_pkg::*;

    t_dp_cmd          w_cmd;
    t_dp_sts          w_sts;
    logic             w_found;
    logic [VAL_W-1:0] w_read_value;
    logic [ST_W-1:0]  w_status;

    // Sequence the clear sweep and each request
    kvdt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // Table storage and result register
    kvdt_datapath #(
        .ENTRIES (ENTRIES)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_op         (i_s_axis_tuser[OP_W-1:0]),
        .i_key        (i_s_axis_tdata[KEY_W-1:0]),
        .i_value      (i_s_axis_tdata[KEY_W +: VAL_W]),
        .o_out_valid  (o_m_axis_tvalid),
        .i_out_ready  (i_m_axis_tready),
        .o_found      (w_found),
        .o_read_value (w_read_value),
        .o_status     (w_status)
    );

    // Pack the result beat
    assign o_m_axis_tdata = w_read_value;
    assign o_m_axis_tuser = {w_status, w_found};

endmodule

[rtl/kvdt_checker.sv]
// Port-level checks of the key/value table, bound to the top level.
module kvdt_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_axis_tvalid,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [kvdt_pkg::OUT_DATA_W-1:0] o_m_axis_tdata,
    input logic [kvdt_pkg::OUT_USER_W-1:0] o_m_axis_tuser
);
    import kvdt_pkg::*;

    logic [ST_W-1:0] w_status;
    logic            w_found;

    assign w_status = o_m_axis_tuser[ST_W:1];
    assign w_found  = o_m_axis_tuser[0];

    // Reset starts the clearing sweep, so no request is taken right after
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready)
        else $error("request channel ready right after reset");

    // One request at a time: ready drops after a request beat
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("request taken while another is in flight");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser))
        else $error("result beat changed while stalled");

    // A hit reports updated, found or deleted
    a_found_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && w_found |->
            (w_status == STAT_UPDATED) || (w_status == STAT_FOUND) ||
            (w_status == STAT_DELETED))
        else $error("found flag with a miss status");

    // A miss reads all ones and never reports a hit status
    a_miss_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !w_found |->
            (o_m_axis_tdata == '1) && (w_status != STAT_UPDATED) &&
            (w_status != STAT_FOUND) && (w_status != STAT_DELETED))
        else $error("miss result with a value or a hit status");

endmodule

bind key_value_dictionary_table kvdt_checker u_kvdt_checker (.*);
